@@ src/hrbp_pkg.sv @@
// shared types and codes for the http request byte parser
// no dependencies; imported by every module of the block
package hrbp_pkg;

   // one-hot parser states
   typedef enum logic [19:0] {
      ST_START       = 20'h00001,
      ST_METHOD      = 20'h00002,
      ST_BEFORE_URL  = 20'h00004,
      ST_URL         = 20'h00008,
      ST_BEFORE_PKEY = 20'h00010,
      ST_PKEY        = 20'h00020,
      ST_BEFORE_PVAL = 20'h00040,
      ST_PVAL        = 20'h00080,
      ST_BEFORE_PROTO = 20'h00100,
      ST_PROTO       = 20'h00200,
      ST_BEFORE_VER  = 20'h00400,
      ST_VER         = 20'h00800,
      ST_HKEY        = 20'h01000,
      ST_HVAL        = 20'h02000,
      ST_GOT_CR      = 20'h04000,
      ST_LINE_START  = 20'h08000,
      ST_BLANK_CR    = 20'h10000,
      ST_BODY        = 20'h20000,
      ST_COMPLETE    = 20'h40000,
      ST_INVALID     = 20'h80000
   } parse_state_type;

   // byte class codes
   localparam logic [3:0] CLS_NONE   = 4'd0;
   localparam logic [3:0] CLS_METHOD = 4'd1;
   localparam logic [3:0] CLS_URL    = 4'd2;
   localparam logic [3:0] CLS_PKEY   = 4'd3;
   localparam logic [3:0] CLS_PVAL   = 4'd4;
   localparam logic [3:0] CLS_PROTO  = 4'd5;
   localparam logic [3:0] CLS_VER    = 4'd6;
   localparam logic [3:0] CLS_HKEY   = 4'd7;
   localparam logic [3:0] CLS_HVAL   = 4'd8;
   localparam logic [3:0] CLS_BODY   = 4'd9;

   // status codes
   localparam logic [1:0] STAT_PARSING  = 2'd0;
   localparam logic [1:0] STAT_COMPLETE = 2'd1;
   localparam logic [1:0] STAT_INVALID  = 2'd2;

   typedef struct packed {
      logic       func;
      logic [7:0] byte_value;
      logic       chunk_end;
   } req_item_type;

   typedef struct packed {
      logic [3:0] byte_class;
      logic       field_end;
      logic [1:0] status;
      logic [7:0] data_out;
   } rsp_item_type;

endpackage

@@ src/hrbp_core.sv @@
// parser state registers and the per-byte next-state and result logic
// depends on hrbp_pkg
module hrbp_core
   import hrbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   output rsp_item_type result
);

   localparam logic [3:0] KEY_LEN = 4'd14;

   localparam logic [1:0] VP_SKIP = 2'd0;
   localparam logic [1:0] VP_POS  = 2'd1;
   localparam logic [1:0] VP_NEG  = 2'd2;
   localparam logic [1:0] VP_DONE = 2'd3;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;

   // "Content-Length"
   function automatic logic [7:0] key_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:  ch = 8'h43;
         4'd1:  ch = 8'h6F;
         4'd2:  ch = 8'h6E;
         4'd3:  ch = 8'h74;
         4'd4:  ch = 8'h65;
         4'd5:  ch = 8'h6E;
         4'd6:  ch = 8'h74;
         4'd7:  ch = 8'h2D;
         4'd8:  ch = 8'h4C;
         4'd9:  ch = 8'h65;
         4'd10: ch = 8'h6E;
         4'd11: ch = 8'h67;
         4'd12: ch = 8'h74;
         4'd13: ch = 8'h68;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   parse_state_type state_ff, state_in;
   logic [3:0] key_pos_ff, key_pos_in;
   logic       key_matching_ff, key_matching_in;
   logic [1:0] value_phase_ff, value_phase_in;
   logic       value_positive_ff, value_positive_in;
   logic       len_seen_ff, len_seen_in;
   logic       len_positive_ff, len_positive_in;

   logic [7:0] c;
   logic       is_blank, is_upper, is_digit, is_space, is_crlf_blank;
   logic       key_is_length, do_key_feed, do_value_feed;
   logic [3:0] feed_pos;
   logic       feed_matching;
   logic [3:0] cls;
   logic       fend;

   assign c             = item.byte_value;
   assign is_blank      = (c == CH_SPACE) || (c == CH_TAB);
   assign is_upper      = (c >= CH_UP_A) && (c <= CH_UP_Z);
   assign is_digit      = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_space      = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   assign is_crlf_blank = (c == CH_CR) || (c == CH_LF) || is_blank;
   assign key_is_length = key_matching_ff && (key_pos_ff == KEY_LEN);

   always_comb begin
      state_in          = state_ff;
      key_pos_in        = key_pos_ff;
      key_matching_in   = key_matching_ff;
      value_phase_in    = value_phase_ff;
      value_positive_in = value_positive_ff;
      len_seen_in       = len_seen_ff;
      len_positive_in   = len_positive_ff;
      cls               = CLS_NONE;
      fend              = 1'b0;
      do_key_feed       = 1'b0;
      do_value_feed     = 1'b0;
      feed_pos          = key_pos_ff;
      feed_matching     = key_matching_ff;

      if (item.func) begin
         state_in          = ST_START;
         key_pos_in        = '0;
         key_matching_in   = 1'b1;
         value_phase_in    = VP_SKIP;
         value_positive_in = 1'b0;
         len_seen_in       = 1'b0;
         len_positive_in   = 1'b0;
      end else begin
         case (state_ff)
            ST_START: begin
               if (is_crlf_blank) begin
                  state_in = ST_START;
               end else if (is_upper) begin
                  state_in = ST_METHOD;
                  cls      = CLS_METHOD;
               end else begin
                  state_in = ST_INVALID;
               end
            end
            ST_METHOD: begin
               if (is_upper) begin
                  cls = CLS_METHOD;
               end else if (is_blank) begin
                  state_in = ST_BEFORE_URL;
                  fend     = 1'b1;
               end else begin
                  state_in = ST_INVALID;
               end
            end
            ST_BEFORE_URL: begin
               if (c == CH_SLASH) begin
                  state_in = ST_URL;
                  cls      = CLS_URL;
               end else if (!is_blank) begin
                  state_in = ST_INVALID;
               end
            end
            ST_URL: begin
               if (c == CH_QUEST) begin
                  state_in = ST_BEFORE_PKEY;
                  fend     = 1'b1;
               end else if (is_blank) begin
                  state_in = ST_BEFORE_PROTO;
                  fend     = 1'b1;
               end else begin
                  cls = CLS_URL;
               end
            end
            ST_BEFORE_PKEY: begin
               if (is_crlf_blank) begin
                  state_in = ST_INVALID;
               end else begin
                  state_in = ST_PKEY;
                  cls      = CLS_PKEY;
               end
            end
            ST_PKEY: begin
               if (c == CH_EQ) begin
                  state_in = ST_BEFORE_PVAL;
                  fend     = 1'b1;
               end else if (is_blank) begin
                  state_in = ST_INVALID;
               end else begin
                  cls = CLS_PKEY;
               end
            end
            ST_BEFORE_PVAL: begin
               if (is_crlf_blank) begin
                  state_in = ST_INVALID;
               end else begin
                  state_in = ST_PVAL;
                  cls      = CLS_PVAL;
               end
            end
            ST_PVAL: begin
               if (c == CH_AMP) begin
                  state_in = ST_BEFORE_PKEY;
                  fend     = 1'b1;
               end else if (is_blank) begin
                  state_in = ST_BEFORE_PROTO;
                  fend     = 1'b1;
               end else begin
                  cls = CLS_PVAL;
               end
            end
            ST_BEFORE_PROTO: begin
               if (!is_blank) begin
                  state_in = ST_PROTO;
                  cls      = CLS_PROTO;
               end
            end
            ST_PROTO: begin
               if (c == CH_SLASH) begin
                  state_in = ST_BEFORE_VER;
                  fend     = 1'b1;
               end else begin
                  cls = CLS_PROTO;
               end
            end
            ST_BEFORE_VER: begin
               if (is_digit) begin
                  state_in = ST_VER;
                  cls      = CLS_VER;
               end else begin
                  state_in = ST_INVALID;
               end
            end
            ST_VER: begin
               if (c == CH_CR) begin
                  state_in = ST_GOT_CR;
                  fend     = 1'b1;
               end else if (is_digit || (c == CH_DOT)) begin
                  cls = CLS_VER;
               end else begin
                  state_in = ST_INVALID;
               end
            end
            ST_HKEY: begin
               if (c == CH_COLON) begin
                  state_in          = ST_HVAL;
                  fend              = 1'b1;
                  value_phase_in    = VP_SKIP;
                  value_positive_in = 1'b0;
               end else begin
                  cls         = CLS_HKEY;
                  do_key_feed = 1'b1;
               end
            end
            ST_HVAL: begin
               if (c == CH_CR) begin
                  state_in = ST_GOT_CR;
                  fend     = 1'b1;
                  if (key_is_length) begin
                     len_seen_in     = 1'b1;
                     len_positive_in = value_positive_ff;
                  end
               end else begin
                  cls           = CLS_HVAL;
                  do_value_feed = key_is_length;
               end
            end
            ST_GOT_CR: begin
               state_in = (c == CH_LF) ? ST_LINE_START : ST_INVALID;
            end
            ST_LINE_START: begin
               if (c == CH_CR) begin
                  state_in = ST_BLANK_CR;
               end else if (is_blank) begin
                  state_in = ST_INVALID;
               end else begin
                  state_in      = ST_HKEY;
                  cls           = CLS_HKEY;
                  do_key_feed   = 1'b1;
                  feed_pos      = '0;
                  feed_matching = 1'b1;
               end
            end
            ST_BLANK_CR: begin
               if (c == CH_LF) begin
                  if (len_seen_ff) begin
                     state_in = len_positive_ff ? ST_BODY : ST_COMPLETE;
                  end else begin
                     state_in = item.chunk_end ? ST_COMPLETE : ST_BODY;
                  end
               end else begin
                  state_in = ST_INVALID;
               end
            end
            ST_BODY: begin
               cls = CLS_BODY;
               if (item.chunk_end) begin
                  state_in = ST_COMPLETE;
               end
            end
            ST_COMPLETE: begin
               state_in = ST_COMPLETE;
            end
            ST_INVALID: begin
               state_in = ST_INVALID;
            end
            default: begin
               state_in = ST_INVALID;
            end
         endcase

         // match the header key against Content-Length
         if (do_key_feed) begin
            key_pos_in      = feed_pos;
            key_matching_in = feed_matching;
            if (feed_matching) begin
               if ((feed_pos < KEY_LEN) && (c == key_char(feed_pos))) begin
                  key_pos_in = feed_pos + 4'd1;
               end else begin
                  key_matching_in = 1'b0;
               end
            end
         end

         // atoi-style sign and digit tracking, only the sign of the value matters
         if (do_value_feed) begin
            case (value_phase_ff)
               VP_SKIP: begin
                  if (!is_space) begin
                     if (c == CH_PLUS) begin
                        value_phase_in = VP_POS;
                     end else if (c == CH_MINUS) begin
                        value_phase_in = VP_NEG;
                     end else if (is_digit) begin
                        value_phase_in = VP_POS;
                        if (c != CH_ZERO) value_positive_in = 1'b1;
                     end else begin
                        value_phase_in = VP_DONE;
                     end
                  end
               end
               VP_POS: begin
                  if (is_digit) begin
                     if (c != CH_ZERO) value_positive_in = 1'b1;
                  end else begin
                     value_phase_in = VP_DONE;
                  end
               end
               VP_NEG: begin
                  if (!is_digit) value_phase_in = VP_DONE;
               end
               default: begin
                  value_phase_in = value_phase_ff;
               end
            endcase
         end
      end
   end

   always_comb begin
      result.byte_class = cls;
      result.field_end  = fend;
      result.data_out   = c;
      if (state_in == ST_COMPLETE) begin
         result.status = STAT_COMPLETE;
      end else if (state_in == ST_INVALID) begin
         result.status = STAT_INVALID;
      end else begin
         result.status = STAT_PARSING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_START;
         key_pos_ff        <= '0;
         key_matching_ff   <= 1'b1;
         value_phase_ff    <= VP_SKIP;
         value_positive_ff <= 1'b0;
         len_seen_ff       <= 1'b0;
         len_positive_ff   <= 1'b0;
      end else if (step_en) begin
         state_ff          <= state_in;
         key_pos_ff        <= key_pos_in;
         key_matching_ff   <= key_matching_in;
         value_phase_ff    <= value_phase_in;
         value_positive_ff <= value_positive_in;
         len_seen_ff       <= len_seen_in;
         len_positive_ff   <= len_positive_in;
      end
   end

endmodule

@@ src/hrbp_out_buf.sv @@
// two-entry result buffer: head register drives the rsp_ ports, second entry skids
// depends on hrbp_pkg
module hrbp_out_buf
   import hrbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output rsp_item_type head,
   output logic         ready
);

   logic [1:0]   count_ff, count_in;
   rsp_item_type head_ff, head_in;
   rsp_item_type skid_ff, skid_in;
   logic         pop;

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign ready     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign head      = head_ff;

   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               head_in = push_item;
            end else begin
               skid_in = push_item;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            head_in  = skid_ff;
         end
         2'b11: begin
            // a push only happens with count below two
            head_in = push_item;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

@@ src/http_request_byte_parser.sv @@
// http request byte parser: input register, parser core and result buffer
// depends on hrbp_pkg, hrbp_core, hrbp_out_buf
//
// One request byte per transfer on req_, one result per byte on rsp_, in order.
// A byte that is taken on req_ goes into an input register, is parsed there by
// the state update of the parser core, and its result is registered in the
// result buffer whose head drives rsp_; the sustained rate is one byte per cycle
// while rsp_stall is low. The result side has a two-entry buffer, so bytes keep
// being taken while a result waits; req_stall rises only when the input
// register is held and both buffer entries are full. req_func high restarts the
// parser; after a request is complete or invalid, bytes pass through with
// byte_class zero and the status repeated until the next restart.
module http_request_byte_parser
   import hrbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_byte_value,
   input  logic       req_chunk_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_byte_class,
   output logic       rsp_field_end,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_data_out
);

   logic         in_vld_ff, in_vld_in;
   req_item_type in_ff, in_in;
   logic         buf_push;
   logic         buf_ready;
   rsp_item_type core_result;
   rsp_item_type head;

   assign req_stall = in_vld_ff && !buf_ready;
   assign buf_push  = in_vld_ff && buf_ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      in_in     = in_ff;
      if (!req_stall) begin
         in_vld_in = req_valid;
         in_in     = '{func: req_func, byte_value: req_byte_value,
                       chunk_end: req_chunk_end};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   hrbp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (buf_push),
      .item    (in_ff),
      .result  (core_result)
   );

   hrbp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (buf_push),
      .push_item (core_result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head      (head),
      .ready     (buf_ready)
   );

   assign rsp_byte_class = head.byte_class;
   assign rsp_field_end  = head.field_end;
   assign rsp_status     = head.status;
   assign rsp_data_out   = head.data_out;

   // a byte that closes a field is itself a delimiter
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_end |-> rsp_byte_class == CLS_NONE)
      else $error("field end byte carries a field class");

   // a finished request only ever reports delimiter or body bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_PARSING |->
         rsp_byte_class == CLS_NONE || rsp_byte_class == CLS_BODY)
      else $error("field class reported with a final status");

   // reset empties the input register and the result buffer
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

@@ tb/http_parse_checker.sv @@
// result checker for the http request byte parser: tracks the parser state per byte
// and compares every rsp_ transfer with the oldest outstanding result
// depends on hrbp_pkg
module http_parse_checker
   import hrbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_byte_value,
   input  logic       req_chunk_end,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [3:0] rsp_byte_class,
   input  logic       rsp_field_end,
   input  logic [1:0] rsp_status,
   input  logic [7:0] rsp_data_out,
   output int         mismatch_total,
   output int         results_owed
);

   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_CR  = 8'h0d;

   localparam logic [8*14-1:0] LEN_KEY = "Content-Length";
   localparam logic [3:0]      KEY_LEN = 4'd14;

   // content-length value scan phases
   localparam logic [1:0] VP_SKIP = 2'd0;
   localparam logic [1:0] VP_POS  = 2'd1;
   localparam logic [1:0] VP_NEG  = 2'd2;
   localparam logic [1:0] VP_DONE = 2'd3;

   parse_state_type ps;
   logic [3:0] key_pos;
   logic       key_ok;
   logic [1:0] val_phase;
   logic       val_pos;
   logic       len_seen;
   logic       len_pos;

   rsp_item_type parsed_bytes[$];
   int           fail_tally = 0;

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SP || c == CH_TAB;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return c >= "A" && c <= "Z";
   endfunction

   task automatic clear_parser();
      ps = ST_START;
      key_pos = '0;
      key_ok = 1'b1;
      val_phase = VP_SKIP;
      val_pos = 1'b0;
      len_seen = 1'b0;
      len_pos = 1'b0;
   endtask

   task automatic feed_key(input logic [7:0] c);
      if (key_ok) begin
         if (key_pos < KEY_LEN && c == LEN_KEY[8*(int'(KEY_LEN) - 1 - int'(key_pos)) +: 8])
            key_pos = key_pos + 4'd1;
         else
            key_ok = 1'b0;
      end
   endtask

   task automatic advance_parser(input logic func, input logic [7:0] c, input logic last,
                                 output rsp_item_type r);
      logic [3:0]      cls;
      logic            fend;
      parse_state_type ns;
      cls = CLS_NONE;
      fend = 1'b0;
      if (func) begin
         clear_parser();
      end else if (ps != ST_COMPLETE && ps != ST_INVALID) begin
         ns = ps;
         case (ps)
            ST_START: begin
               if (!(c == CH_CR || c == CH_LF || is_blank(c))) begin
                  if (is_upper(c)) begin
                     ns = ST_METHOD;
                     cls = CLS_METHOD;
                  end else ns = ST_INVALID;
               end
            end
            ST_METHOD: begin
               if (is_upper(c)) cls = CLS_METHOD;
               else if (is_blank(c)) begin
                  ns = ST_BEFORE_URL;
                  fend = 1'b1;
               end else ns = ST_INVALID;
            end
            ST_BEFORE_URL: begin
               if (c == "/") begin
                  ns = ST_URL;
                  cls = CLS_URL;
               end else if (!is_blank(c)) ns = ST_INVALID;
            end
            ST_URL: begin
               if (c == "?") begin
                  ns = ST_BEFORE_PKEY;
                  fend = 1'b1;
               end else if (is_blank(c)) begin
                  ns = ST_BEFORE_PROTO;
                  fend = 1'b1;
               end else cls = CLS_URL;
            end
            ST_BEFORE_PKEY: begin
               if (c == CH_CR || c == CH_LF || is_blank(c)) ns = ST_INVALID;
               else begin
                  ns = ST_PKEY;
                  cls = CLS_PKEY;
               end
            end
            ST_PKEY: begin
               if (c == "=") begin
                  ns = ST_BEFORE_PVAL;
                  fend = 1'b1;
               end else if (is_blank(c)) ns = ST_INVALID;
               else cls = CLS_PKEY;
            end
            ST_BEFORE_PVAL: begin
               if (c == CH_CR || c == CH_LF || is_blank(c)) ns = ST_INVALID;
               else begin
                  ns = ST_PVAL;
                  cls = CLS_PVAL;
               end
            end
            ST_PVAL: begin
               if (c == "&") begin
                  ns = ST_BEFORE_PKEY;
                  fend = 1'b1;
               end else if (is_blank(c)) begin
                  ns = ST_BEFORE_PROTO;
                  fend = 1'b1;
               end else cls = CLS_PVAL;
            end
            ST_BEFORE_PROTO: begin
               if (!is_blank(c)) begin
                  ns = ST_PROTO;
                  cls = CLS_PROTO;
               end
            end
            ST_PROTO: begin
               if (c == "/") begin
                  ns = ST_BEFORE_VER;
                  fend = 1'b1;
               end else cls = CLS_PROTO;
            end
            ST_BEFORE_VER: begin
               if (is_digit(c)) begin
                  ns = ST_VER;
                  cls = CLS_VER;
               end else ns = ST_INVALID;
            end
            ST_VER: begin
               if (c == CH_CR) begin
                  ns = ST_GOT_CR;
                  fend = 1'b1;
               end else if (is_digit(c) || c == ".") cls = CLS_VER;
               else ns = ST_INVALID;
            end
            ST_HKEY: begin
               if (c == ":") begin
                  ns = ST_HVAL;
                  fend = 1'b1;
                  val_phase = VP_SKIP;
                  val_pos = 1'b0;
               end else begin
                  cls = CLS_HKEY;
                  feed_key(c);
               end
            end
            ST_HVAL: begin
               if (c == CH_CR) begin
                  ns = ST_GOT_CR;
                  fend = 1'b1;
                  if (key_ok && key_pos == KEY_LEN) begin
                     len_seen = 1'b1;
                     len_pos = val_pos;
                  end
               end else begin
                  cls = CLS_HVAL;
                  // atoi-style scan, only the sign of the result matters
                  if (key_ok && key_pos == KEY_LEN) begin
                     case (val_phase)
                        VP_SKIP: begin
                           if (!(c == CH_SP || (c >= 8'd9 && c <= 8'd13))) begin
                              if (c == "+") val_phase = VP_POS;
                              else if (c == "-") val_phase = VP_NEG;
                              else if (is_digit(c)) begin
                                 val_phase = VP_POS;
                                 if (c != "0") val_pos = 1'b1;
                              end else val_phase = VP_DONE;
                           end
                        end
                        VP_POS: begin
                           if (is_digit(c)) begin
                              if (c != "0") val_pos = 1'b1;
                           end else val_phase = VP_DONE;
                        end
                        VP_NEG: begin
                           if (!is_digit(c)) val_phase = VP_DONE;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            ST_GOT_CR: begin
               ns = (c == CH_LF) ? ST_LINE_START : ST_INVALID;
            end
            ST_LINE_START: begin
               if (c == CH_CR) ns = ST_BLANK_CR;
               else if (is_blank(c)) ns = ST_INVALID;
               else begin
                  ns = ST_HKEY;
                  cls = CLS_HKEY;
                  key_pos = '0;
                  key_ok = 1'b1;
                  feed_key(c);
               end
            end
            ST_BLANK_CR: begin
               if (c == CH_LF) begin
                  if (len_seen) ns = len_pos ? ST_BODY : ST_COMPLETE;
                  else ns = last ? ST_COMPLETE : ST_BODY;
               end else ns = ST_INVALID;
            end
            ST_BODY: begin
               cls = CLS_BODY;
               if (last) ns = ST_COMPLETE;
            end
            default: ns = ST_INVALID;
         endcase
         ps = ns;
      end
      r.byte_class = cls;
      r.field_end = fend;
      r.status = (ps == ST_COMPLETE) ? STAT_COMPLETE :
                 (ps == ST_INVALID) ? STAT_INVALID : STAT_PARSING;
      r.data_out = c;
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         clear_parser();
         parsed_bytes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_byte_class, rsp_field_end, rsp_status, rsp_data_out};
            if (parsed_bytes.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10)
                  $display("unexpected result transfer: class %0d end %0d status %0d data %h",
                           got.byte_class, got.field_end, got.status, got.data_out);
            end else begin
               want = parsed_bytes.pop_front();
               if (got != want) begin
                  fail_tally++;
                  if (fail_tally <= 10)
                     $display({"mismatch: class exp %0d got %0d, end exp %0d got %0d, ",
                               "status exp %0d got %0d, data exp %h got %h"},
                              want.byte_class, got.byte_class, want.field_end, got.field_end,
                              want.status, got.status, want.data_out, got.data_out);
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_parser(req_func, req_byte_value, req_chunk_end, want);
            parsed_bytes.push_back(want);
         end
      end
      results_owed <= parsed_bytes.size();
      mismatch_total <= fail_tally;
   end

endmodule

@@ tb/testbench.sv @@
// top of the http request byte parser testbench: builds request byte streams,
// drives req_ and rsp_stall with random gaps and gives the verdict
// depends on hrbp_pkg, http_request_byte_parser, http_parse_checker
module testbench;
   import hrbp_pkg::*;

   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam int ITEM_GOAL  = 1900;
   localparam int IDLE_LIMIT = 2000;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_func = 1'b0;
   logic [7:0] req_byte_value = 8'h00;
   logic       req_chunk_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_byte_class;
   logic       rsp_field_end;
   logic [1:0] rsp_status;
   logic [7:0] rsp_data_out;
   int         mismatch_total;
   int         results_owed;

   req_item_type byte_plan[$];
   int           planned = 0;
   bit           tally_on = 1'b1;
   bit           quiet_send = 1'b0;
   int           req_pos = 0;
   int           corrupt_at = -1;

   http_request_byte_parser dut (.*);

   http_parse_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] byte_except(input logic [7:0] x1, x2, x3, x4, x5);
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c == x1 || c == x2 || c == x3 || c == x4 || c == x5)
         c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic logic rand_chunk();
      return $urandom_range(0, 9) == 0;
   endfunction

   function automatic logic [7:0] rand_blank();
      return $urandom_range(0, 1) ? CH_SP : CH_TAB;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_send || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic put(input logic [7:0] c, input logic last);
      req_item_type it;
      // occasionally break a well-formed request at one byte
      if (req_pos == corrupt_at) c = 8'($urandom_range(0, 255));
      req_pos++;
      it = {1'b0, c, last};
      byte_plan.push_back(it);
      if (tally_on) planned++;
   endtask

   task automatic put_restart();
      req_item_type it;
      it = {1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))};
      byte_plan.push_back(it);
      planned++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put(s[i], rand_chunk());
   endtask

   task automatic put_length_value();
      int k;
      int n;
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 4))
            0: put(CH_SP, rand_chunk());
            1: put(CH_TAB, rand_chunk());
            2: put(CH_LF, rand_chunk());
            3: put(8'h0b, rand_chunk());
            default: put(8'h0c, rand_chunk());
         endcase
      end
      k = $urandom_range(0, 9);
      if (k < 2) put("+", rand_chunk());
      else if (k == 2) put("-", rand_chunk());
      case ($urandom_range(0, 5))
         0: n = $urandom_range(1, 3);         // one to three digits
         1, 2, 3: n = $urandom_range(1, 4);
         4: n = $urandom_range(18, 24);       // far beyond 32 bits
         default: n = 0;
      endcase
      k = $urandom_range(0, 5);
      for (int i = 0; i < n; i++)
         put((k == 0) ? "0" : 8'("0" + $urandom_range(0, 9)), rand_chunk());
      if ($urandom_range(0, 3) == 0) begin
         put($urandom_range(0, 1) ? "x" : CH_SP, rand_chunk());
         put(8'("0" + $urandom_range(0, 9)), rand_chunk());
      end
   endtask

   task automatic build_request();
      int    n;
      int    body_len;
      int    start_len;
      string key;
      put_restart();
      if ($urandom_range(0, 19) == 0) quiet_send = ~quiet_send;
      req_pos = 0;
      corrupt_at = ($urandom_range(0, 99) < 12) ? $urandom_range(0, 60) : -1;
      start_len = planned;
      if ($urandom_range(0, 99) < 8) begin
         // noise: random bytes, mostly rejected early
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)), rand_chunk());
         return;
      end
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 3))
            0: put(CH_CR, rand_chunk());
            1: put(CH_LF, rand_chunk());
            default: put(rand_blank(), rand_chunk());
         endcase
      end
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) put(8'("A" + $urandom_range(0, 25)), rand_chunk());
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) put(rand_blank(), rand_chunk());
      put("/", rand_chunk());
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) put(byte_except("?", CH_SP, CH_TAB, CH_SP, CH_SP), rand_chunk());
      if ($urandom_range(0, 99) < 40) begin
         put("?", rand_chunk());
         n = $urandom_range(1, 3);
         for (int p = 0; p < n; p++) begin
            if (p > 0) put("&", rand_chunk());
            for (int i = $urandom_range(1, 3); i > 0; i--)
               put(byte_except("=", CH_SP, CH_TAB, CH_CR, CH_LF), rand_chunk());
            put("=", rand_chunk());
            for (int i = $urandom_range(1, 3); i > 0; i--)
               put(byte_except("&", CH_SP, CH_TAB, CH_CR, CH_LF), rand_chunk());
         end
      end
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) put(rand_blank(), rand_chunk());
      if ($urandom_range(0, 1)) put_text("HTTP");
      else begin
         for (int i = $urandom_range(1, 4); i > 0; i--)
            put(byte_except("/", CH_SP, CH_TAB, CH_SP, CH_SP), rand_chunk());
      end
      put("/", rand_chunk());
      put(8'("0" + $urandom_range(0, 9)), rand_chunk());
      for (int i = $urandom_range(0, 3); i > 0; i--)
         put($urandom_range(0, 3) == 0 ? "." : 8'("0" + $urandom_range(0, 9)), rand_chunk());
      put(CH_CR, rand_chunk());
      put(CH_LF, rand_chunk());
      for (int h = $urandom_range(0, 3); h > 0; h--) begin
         n = $urandom_range(0, 9);
         if (n < 5) begin
            put_text("Content-Length");
         end else if (n < 8) begin
            case ($urandom_range(0, 3))
               0: key = "Content-Lengt";
               1: key = "content-length";
               2: key = "Content-LengthX";
               default: key = "Content-Type";
            endcase
            put_text(key);
         end else begin
            for (int i = $urandom_range(1, 5); i > 0; i--)
               put(byte_except(":", CH_SP, CH_TAB, CH_CR, CH_LF), rand_chunk());
         end
         put(":", rand_chunk());
         if (n < 8) put_length_value();
         else begin
            for (int i = $urandom_range(0, 6); i > 0; i--)
               put(byte_except(CH_CR, CH_CR, CH_CR, CH_CR, CH_CR), rand_chunk());
         end
         put(CH_CR, rand_chunk());
         put(CH_LF, rand_chunk());
      end
      body_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      put(CH_CR, rand_chunk());
      put(CH_LF, (body_len == 0) ? 1'b1 : ($urandom_range(0, 3) == 0));
      for (int i = 1; i <= body_len; i++) put(8'($urandom_range(0, 255)), i == body_len);
      if ($urandom_range(0, 99) < 15) begin
         // bytes after the end of a request are only passed through
         tally_on = 1'b0;
         for (int i = $urandom_range(1, 3); i > 0; i--)
            put(8'($urandom_range(0, 255)), rand_chunk());
         tally_on = 1'b1;
      end
      if (planned == start_len) planned++;
   endtask

   task automatic send_item(input req_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_byte_value <= it.byte_value;
      req_chunk_end <= it.chunk_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // result side back-pressure in bursts, with calm stretches
   initial begin
      int run_left;
      int span;
      bit hold;
      bit calm;
      run_left = 0;
      span = 0;
      hold = 1'b0;
      calm = 1'b0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            calm = $urandom_range(0, 3) == 0;
            span = $urandom_range(50, 400);
         end
         span--;
         if (run_left == 0) begin
            if (calm) begin
               hold = 1'b0;
               run_left = 1;
            end else begin
               hold = $urandom_range(0, 99) < 35;
               if (hold)
                  run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(1, 3);
               else
                  run_left = $urandom_range(1, 6);
            end
         end
         run_left--;
         rsp_stall <= hold;
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: bad first byte, byte after invalid, minimal request, byte after complete
      put_restart();
      put("a", 1'b0);
      put(8'hff, 1'b1);
      put_restart();
      put_text("Z / X/9");
      put(CH_CR, 1'b0);
      put(CH_LF, 1'b0);
      put(CH_CR, 1'b0);
      put(CH_LF, 1'b1);
      put(8'h80, 1'b0);
      while (byte_plan.size() > 0) send_item(byte_plan.pop_front());

      while (planned < ITEM_GOAL) begin
         build_request();
         while (byte_plan.size() > 0) send_item(byte_plan.pop_front());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_total == 0 && results_owed == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/hrbp_pkg.sv
src/hrbp_core.sv
src/hrbp_out_buf.sv
src/http_request_byte_parser.sv
tb/http_parse_checker.sv
tb/testbench.sv
